/* sv/brbc_pkg.sv */
// Shared types and constants for the block rotate blit clipper.
// No dependencies; every other file imports this package.
package brbc_pkg;

  // Grid geometry
  localparam int BLOCK_SIZE    = 32;
  localparam int BLOCKS_X      = 6;
  localparam int BLOCKS_Y      = 7;
  localparam int CAMERA_OFFSET = 32;
  localparam int X_FIRST = -(((CAMERA_OFFSET + BLOCK_SIZE - 1) / BLOCK_SIZE) + 2);
  localparam int Y_FIRST = -(((CAMERA_OFFSET + BLOCK_SIZE - 1) / BLOCK_SIZE) + 2);

  // Sequencer counter widths, wide enough to hold the count itself
  localparam int COL_W = $clog2(BLOCKS_X + 1);
  localparam int ROW_W = $clog2(BLOCKS_Y + 1);

  // Signed working width for coordinates before clipping
  localparam int COORD_W = 12;
  typedef logic signed [COORD_W-1:0] coord_t;

  localparam int SHIFT_W = 5;
  localparam int COUNT_W = 8;
  localparam int POS_W   = 8;
  localparam int SIZE_W  = 6;

  // Frame job queue between front and back
  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd4;

  localparam logic [POS_W-1:0] CENTER_X_RST    = 8'd64;
  localparam logic [POS_W-1:0] CENTER_Y_RST    = 8'd48;
  localparam logic [POS_W-1:0] AREA_WIDTH_RST  = 8'd144;
  localparam logic [POS_W-1:0] AREA_HEIGHT_RST = 8'd97;

  typedef struct packed {
    logic             enabled;
    logic [POS_W-1:0] center_x;
    logic [POS_W-1:0] center_y;
    logic [POS_W-1:0] area_width;
    logic [POS_W-1:0] area_height;
  } cfg_t;

  // One frame of work: pixel shift and the buffer to read from
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic               src_buffer;
  } frame_job_t;

  // One copy command
  typedef struct packed {
    logic [POS_W-1:0]  src_x;
    logic [POS_W-1:0]  src_y;
    logic [POS_W-1:0]  dst_x;
    logic [POS_W-1:0]  dst_y;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              src_buffer;
  } rect_t;

endpackage

/* sv/brbc_front.sv */
// Front end: configuration registers, tick acceptance, frame counter and
// buffer select. Depends on brbc_pkg.
module brbc_front import brbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  restart,
  input  logic                  q_full,
  output logic                  q_push,
  output frame_job_t            q_job,
  output cfg_t                  cfg
);

  logic [COUNT_W-1:0] frame_count;
  logic               write_buffer;
  logic               accept;
  logic [COUNT_W-1:0] fc_base;
  logic [COUNT_W-1:0] fc_next;
  logic               wb_base;
  logic               cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled     <= 1'b0;
      cfg.center_x    <= CENTER_X_RST;
      cfg.center_y    <= CENTER_Y_RST;
      cfg.area_width  <= AREA_WIDTH_RST;
      cfg.area_height <= AREA_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLED:     cfg.enabled     <= cfg_data[0];
        REG_CENTER_X:    cfg.center_x    <= cfg_data[POS_W-1:0];
        REG_CENTER_Y:    cfg.center_y    <= cfg_data[POS_W-1:0];
        REG_AREA_WIDTH:  cfg.area_width  <= cfg_data[POS_W-1:0];
        REG_AREA_HEIGHT: cfg.area_height <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick request handling
  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  assign fc_base  = restart ? '0 : frame_count;
  assign wb_base  = restart ? 1'b0 : write_buffer;
  assign fc_next  = fc_base + COUNT_W'(1);
  assign q_push   = accept & cfg.enabled;

  // Shift is the bit reversal of the new count's low bits
  always_comb begin
    for (int i = 0; i < SHIFT_W; i++) begin
      q_job.shift[i] = fc_next[SHIFT_W-1-i];
    end
    q_job.src_buffer = ~wb_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count  <= '0;
      write_buffer <= 1'b0;
    end else if (accept) begin
      frame_count  <= cfg.enabled ? fc_next : fc_base;
      write_buffer <= cfg.enabled ? ~wb_base : wb_base;
    end
  end

endmodule

/* sv/brbc_job_queue.sv */
// Short queue of frame jobs between front and back end.
// Depends on brbc_pkg.
module brbc_job_queue import brbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_job_t push_job,
  input  logic       pop,
  output logic       full,
  output logic       head_valid,
  output frame_job_t head
);

  frame_job_t           slots [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr;
  logic [JOB_PTR_W-1:0] rd_ptr;
  logic [JOB_CNT_W-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (count == JOB_CNT_W'(JOB_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  function automatic logic [JOB_PTR_W-1:0] bump(logic [JOB_PTR_W-1:0] p);
    return (p == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : p + JOB_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop)      count <= count + JOB_CNT_W'(1);
      else if (do_pop && !do_push) count <= count - JOB_CNT_W'(1);
    end
  end

endmodule

/* sv/brbc_back.sv */
// Back end: walks the block grid per frame job, clips each rectangle and
// emits copy commands with the final one flagged. Depends on brbc_pkg.
module brbc_back import brbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  frame_job_t q_job,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output rect_t      out_rect,
  output logic       out_last
);

  typedef struct packed {
    coord_t d;
    coord_t s;
    coord_t len;
  } axis_t;

  // Clip one axis: destination low, source low, source high, destination high
  function automatic axis_t clip_axis(coord_t d_in, coord_t s_in, coord_t lim);
    coord_t d;
    coord_t s;
    coord_t n;
    axis_t  r;
    d = d_in;
    s = s_in;
    n = coord_t'(BLOCK_SIZE);
    if (d < 0) begin
      s = s - d;
      n = n + d;
      d = '0;
    end
    if (s < 0) begin
      d = d - s;
      n = n + s;
      s = '0;
    end
    if (s + n > lim) n = lim - s;
    if (d + n > lim) n = lim - d;
    r.d   = d;
    r.s   = s;
    r.len = n;
    return r;
  endfunction

  // Sequencer state
  logic               busy;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [SHIFT_W-1:0] shift;
  logic               src_buffer;
  logic               at_end;
  logic               seq_step;

  // Geometry stage
  logic   s1_valid;
  logic   s1_eof;
  logic   s1_buf;
  coord_t s1_dx, s1_dy, s1_sx, s1_sy;
  coord_t bx, by, gx, gy, gsx, gsy;

  // Clip, pending and output
  axis_t  hx, vy;
  logic   survive;
  rect_t  new_rect;
  rect_t  pend;
  logic   pend_valid;
  logic   pend_final;
  logic   out_free;
  logic   flush;
  logic   s1_take;
  logic   s1_load_ok;

  assign out_free   = ~out_valid | out_ready;
  assign flush      = pend_valid & pend_final;
  assign s1_take    = s1_valid & out_free & ~flush;
  assign s1_load_ok = ~s1_valid | s1_take;
  assign seq_step   = busy & s1_load_ok;
  assign q_pop      = ~busy & q_valid;
  assign at_end     = (col == COL_W'(BLOCKS_X - 1)) && (row == ROW_W'(BLOCKS_Y - 1));

  // Block position from the grid counters
  always_comb begin
    bx  = coord_t'(X_FIRST) + $signed({{(COORD_W-COL_W){1'b0}}, col});
    by  = coord_t'(Y_FIRST) + $signed({{(COORD_W-ROW_W){1'b0}}, row});
    gx  = $signed({{(COORD_W-POS_W){1'b0}}, cfg.center_x}) + bx * coord_t'(BLOCK_SIZE)
          + $signed({{(COORD_W-SHIFT_W){1'b0}}, shift});
    gy  = $signed({{(COORD_W-POS_W){1'b0}}, cfg.center_y}) + by * coord_t'(BLOCK_SIZE)
          + $signed({{(COORD_W-SHIFT_W){1'b0}}, shift});
    gsx = gx - (by + coord_t'(1)) - (bx + coord_t'(1));
    gsy = gy - (by + coord_t'(1)) + (bx + coord_t'(1));
  end

  // Grid walk, one block per step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      col  <= '0;
      row  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      col  <= '0;
      row  <= '0;
    end else if (seq_step) begin
      if (at_end) begin
        busy <= 1'b0;
      end else if (col == COL_W'(BLOCKS_X - 1)) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      shift      <= q_job.shift;
      src_buffer <= q_job.src_buffer;
    end
  end

  // Geometry register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (seq_step) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_step) begin
      s1_dx  <= gx;
      s1_dy  <= gy;
      s1_sx  <= gsx;
      s1_sy  <= gsy;
      s1_eof <= at_end;
      s1_buf <= src_buffer;
    end
  end

  // Clipping against the area
  always_comb begin
    hx = clip_axis(s1_dx, s1_sx, $signed({{(COORD_W-POS_W){1'b0}}, cfg.area_width}));
    vy = clip_axis(s1_dy, s1_sy, $signed({{(COORD_W-POS_W){1'b0}}, cfg.area_height}));
    survive             = (hx.len > 0) && (vy.len > 0);
    new_rect.src_x      = hx.s[POS_W-1:0];
    new_rect.src_y      = vy.s[POS_W-1:0];
    new_rect.dst_x      = hx.d[POS_W-1:0];
    new_rect.dst_y      = vy.d[POS_W-1:0];
    new_rect.width      = hx.len[SIZE_W-1:0];
    new_rect.height     = vy.len[SIZE_W-1:0];
    new_rect.src_buffer = s1_buf;
  end

  // Hold one survivor back so the frame's final command can be flagged
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_final <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (flush && out_free) begin
        out_rect   <= pend;
        out_last   <= 1'b1;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
        pend_final <= 1'b0;
      end else if (s1_take) begin
        if (survive) begin
          if (pend_valid) begin
            out_rect  <= pend;
            out_last  <= 1'b0;
            out_valid <= 1'b1;
          end
          pend       <= new_rect;
          pend_valid <= 1'b1;
          pend_final <= s1_eof;
        end else if (pend_valid && s1_eof) begin
          out_rect   <= pend;
          out_last   <= 1'b1;
          out_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end
      end
    end
  end

endmodule

/* sv/block_rotate_blit_clipper_top.sv */
// Top level of the block rotate blit clipper.
// Depends on brbc_pkg, brbc_front, brbc_job_queue and brbc_back.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; writes
//   are always taken (cfg_ready is tied high) and should be made while idle.
//   Tick channel: one request per frame on in_valid/in_ready with restart.
//   A tick with restart clears the frame counter and buffer select first.
//   While enabled, each tick queues one frame job; the job queue holds two,
//   so in_ready drops only when two frames are already waiting.
//   Result channel: out_valid/out_ready carries one copy command per
//   surviving block, last set on the frame's final command.
//   Path: a taken tick passes the job queue, grid walk, geometry register
//   and held survivor before its first command is valid; each survivor
//   waits for the next one or the end of the walk, so sparse frames show
//   their first command later. Throughput: one grid block per cycle, set by
//   the back end's walk unless the output stalls; jobs do not overlap.
//   A stalled receiver holds the output register; the back end stops and
//   ticks still collect in the queue. Reset restores the register defaults,
//   clears counters and queue; there is no clearing pass.
module block_rotate_blit_clipper_top import brbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [POS_W-1:0]      src_x,
  output logic [POS_W-1:0]      src_y,
  output logic [POS_W-1:0]      dst_x,
  output logic [POS_W-1:0]      dst_y,
  output logic [SIZE_W-1:0]     width,
  output logic [SIZE_W-1:0]     height,
  output logic                  src_buffer,
  output logic                  last
);

  cfg_t       cfg;
  logic       q_full;
  logic       q_push;
  frame_job_t q_push_job;
  logic       q_pop;
  logic       q_valid;
  frame_job_t q_head;
  rect_t      out_rect;

  brbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_push_job),
    .cfg       (cfg)
  );

  brbc_job_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_push_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head)
  );

  brbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_job     (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rect  (out_rect),
    .out_last  (last)
  );

  assign src_x      = out_rect.src_x;
  assign src_y      = out_rect.src_y;
  assign dst_x      = out_rect.dst_x;
  assign dst_y      = out_rect.dst_y;
  assign width      = out_rect.width;
  assign height     = out_rect.height;
  assign src_buffer = out_rect.src_buffer;

endmodule

/* sv/brbc_checker.sv */
// Port-level checks for the block rotate blit clipper, bound to the top.
// Depends on brbc_pkg and block_rotate_blit_clipper_top.
module brbc_checker import brbc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [POS_W-1:0]      src_x,
  input logic [POS_W-1:0]      src_y,
  input logic [POS_W-1:0]      dst_x,
  input logic [POS_W-1:0]      dst_y,
  input logic [SIZE_W-1:0]     width,
  input logic [SIZE_W-1:0]     height,
  input logic                  src_buffer,
  input logic                  last
);

  // A stalled command holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(src_x) && $stable(src_y)
      && $stable(dst_x) && $stable(dst_y) && $stable(width) && $stable(height)
      && $stable(src_buffer) && $stable(last))
    else $error("stalled command changed");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Commands of one frame read the same buffer
  a_frame_buffer: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !out_valid || src_buffer == $past(src_buffer))
    else $error("buffer select changed within a frame");

  // A surviving rectangle is never empty
  a_nonzero_size: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (BLOCK_SIZE == 64) || (width != '0 && height != '0))
    else $error("empty rectangle emitted");

endmodule

bind block_rotate_blit_clipper_top brbc_checker u_checker (.*);

/* verif/block_rotate_blit_clipper_top_tb.sv */
// Self-checking testbench for block_rotate_blit_clipper_top: frame ticks go in,
// predicted copy commands are compared field by field. Depends on brbc_pkg and the top.
module block_rotate_blit_clipper_top_tb;
  import brbc_pkg::*;

  localparam int RANDOM_TICKS  = 460;
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_PHASE    = 280;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_AREA_HEIGHT + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    rect_t rect;
    logic  last;
  } copy_cmd_t;

  // Predicts copy commands for each tick and checks the ones that come out
  class blit_scoreboard;
    copy_cmd_t        expected_q[$];
    logic             enabled;
    logic [POS_W-1:0] center_x, center_y, area_width, area_height;
    logic [7:0]       frame_count;
    logic             write_buffer;
    int               errors;

    function new();
      enabled      = 1'b0;
      center_x     = CENTER_X_RST;
      center_y     = CENTER_Y_RST;
      area_width   = AREA_WIDTH_RST;
      area_height  = AREA_HEIGHT_RST;
      frame_count  = '0;
      write_buffer = 1'b0;
      errors       = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ENABLED:     enabled     = data[0];
        REG_CENTER_X:    center_x    = data;
        REG_CENTER_Y:    center_y    = data;
        REG_AREA_WIDTH:  area_width  = data;
        REG_AREA_HEIGHT: area_height = data;
        default: ;
      endcase
    endfunction

    function logic [4:0] bitrev5(logic [4:0] v);
      logic [4:0] r;
      for (int i = 0; i < 5; i++) r[i] = v[4-i];
      return r;
    endfunction

    // One accepted tick: walk the grid, clip both rectangles, queue survivors
    function void note_tick(logic restart_bit);
      int        shift, bx, by, dx, dy, sx, sy, w, h, d, aw, ah;
      bit        have_prev;
      copy_cmd_t prev, cmd;
      if (restart_bit) begin
        frame_count  = '0;
        write_buffer = 1'b0;
      end
      if (!enabled) return;
      frame_count = frame_count + 8'd1;
      shift = int'(bitrev5(frame_count[4:0]));
      aw = int'(area_width);
      ah = int'(area_height);
      have_prev = 0;
      for (int row = 0; row < BLOCKS_Y; row++) begin
        by = Y_FIRST + row;
        for (int col = 0; col < BLOCKS_X; col++) begin
          bx = X_FIRST + col;
          dx = int'(center_x) + bx * BLOCK_SIZE + shift;
          dy = int'(center_y) + by * BLOCK_SIZE + shift;
          sx = dx - (by + 1) - (bx + 1);
          sy = dy - (by + 1) + (bx + 1);
          w = BLOCK_SIZE;
          h = BLOCK_SIZE;
          // horizontal: dst left, src left, src right, dst right
          if (dx < 0) begin d = -dx; sx += d; w -= d; dx = 0; end
          if (sx < 0) begin d = -sx; dx += d; w -= d; sx = 0; end
          if (sx + w > aw) w = aw - sx;
          if (dx + w > aw) w = aw - dx;
          // vertical: dst top, src top, src bottom, dst bottom
          if (dy < 0) begin d = -dy; sy += d; h -= d; dy = 0; end
          if (sy < 0) begin d = -sy; dy += d; h -= d; sy = 0; end
          if (sy + h > ah) h = ah - sy;
          if (dy + h > ah) h = ah - dy;
          if (w <= 0 || h <= 0) continue;
          cmd.rect.src_x      = POS_W'(sx);
          cmd.rect.src_y      = POS_W'(sy);
          cmd.rect.dst_x      = POS_W'(dx);
          cmd.rect.dst_y      = POS_W'(dy);
          cmd.rect.width      = SIZE_W'(w);
          cmd.rect.height     = SIZE_W'(h);
          cmd.rect.src_buffer = ~write_buffer;
          cmd.last            = 1'b0;
          if (have_prev) expected_q.push_back(prev);
          prev = cmd;
          have_prev = 1;
        end
      end
      if (have_prev) begin
        prev.last = 1'b1;
        expected_q.push_back(prev);
      end
      write_buffer = ~write_buffer;
    endfunction

    function void cmp_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(copy_cmd_t got);
      copy_cmd_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected copy command, expected none, got src %0d,%0d dst %0d,%0d",
                 $time, got.rect.src_x, got.rect.src_y, got.rect.dst_x, got.rect.dst_y);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp_field("src_x", want.rect.src_x, got.rect.src_x);
      cmp_field("src_y", want.rect.src_y, got.rect.src_y);
      cmp_field("dst_x", want.rect.dst_x, got.rect.dst_x);
      cmp_field("dst_y", want.rect.dst_y, got.rect.dst_y);
      cmp_field("width", want.rect.width, got.rect.width);
      cmp_field("height", want.rect.height, got.rect.height);
      cmp_field("src_buffer", want.rect.src_buffer, got.rect.src_buffer);
      cmp_field("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  restart = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [POS_W-1:0]      src_x, src_y, dst_x, dst_y;
  logic [SIZE_W-1:0]     width, height;
  logic                  src_buffer, last;

  int send_idle_pct = 6;
  int recv_idle_pct = 75;
  blit_scoreboard sb;

  block_rotate_blit_clipper_top uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .restart(restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .src_x(src_x), .src_y(src_y), .dst_x(dst_x), .dst_y(dst_y),
    .width(width), .height(height), .src_buffer(src_buffer), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    copy_cmd_t got;
    if (!rst && out_valid && out_ready) begin
      got.rect = '{src_x: src_x, src_y: src_y, dst_x: dst_x, dst_y: dst_y,
                   width: width, height: height, src_buffer: src_buffer};
      got.last = last;
      sb.check_result(got);
    end
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Sender tasks
  task automatic tick_idle();
    in_valid <= 1'b0;
  endtask

  task automatic send_tick(input logic r);
    in_valid <= 1'b1;
    restart  <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic pause_until_drained();
    tick_idle();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Settings change only with the block idle, including zero-result frames in flight
  task automatic apply_settings(input logic en, input logic [POS_W-1:0] cx,
                                input logic [POS_W-1:0] cy, input logic [POS_W-1:0] aw,
                                input logic [POS_W-1:0] ah, input bit spare);
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_ENABLED, {7'($urandom_range(127)), en});
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_AREA_WIDTH, aw);
    write_reg(REG_AREA_HEIGHT, ah);
    if (spare)
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idle_mode(input int n);
    if (n < RANDOM_TICKS / 3) begin
      send_idle_pct = 6;
      recv_idle_pct = 75;
    end else if (n < 2 * RANDOM_TICKS / 3) begin
      send_idle_pct = 75;
      recv_idle_pct = 6;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_border();
    case ($urandom_range(9))
      0: return '0;
      1: return POS_W'(1);
      2: return '1;
      default: return POS_W'($urandom_range(255, 1));
    endcase
  endfunction

  initial begin
    int  rand_sent, phase_len, restart_pct;
    bit  first_phase;
    logic r;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_idle_mode(0);

    // Disabled from reset; restart while disabled only clears state
    send_tick(1'b0);
    send_tick(1'b1);
    // Reset geometry, then a restart mid-run
    apply_settings(1'b1, CENTER_X_RST, CENTER_Y_RST, AREA_WIDTH_RST, AREA_HEIGHT_RST, 0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    // Full area, origin at the top-left corner
    apply_settings(1'b1, 8'd0, 8'd0, 8'd255, 8'd255, 0);
    repeat (3) send_tick(1'b0);
    // Origin at the far corner
    apply_settings(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 0);
    repeat (2) send_tick(1'b0);
    // One-pixel area
    apply_settings(1'b1, 8'd255, 8'd255, 8'd1, 8'd1, 0);
    repeat (2) send_tick(1'b0);
    apply_settings(1'b1, 8'd0, 8'd0, 8'd1, 8'd1, 0);
    repeat (2) send_tick(1'b0);
    // Zero borders: everything clipped away, buffer still toggles
    apply_settings(1'b1, 8'd128, 8'd128, 8'd0, 8'd0, 0);
    repeat (2) send_tick(1'b0);
    apply_settings(1'b1, 8'd0, 8'd255, 8'd255, 8'd0, 0);
    send_tick(1'b0);
    // Wide, shallow area, exercises source top clipping; unused index ignored
    apply_settings(1'b1, 8'd100, 8'd20, 8'd255, 8'd40, 1);
    repeat (2) send_tick(1'b0);
    // Disabled again, with restart
    apply_settings(1'b0, 8'd64, 8'd48, 8'd144, 8'd97, 0);
    send_tick(1'b1);
    send_tick(1'b0);

    // Random phases; the first is long enough for the frame counter to wrap
    rand_sent = 0;
    first_phase = 1;
    while (rand_sent < RANDOM_TICKS) begin
      if (first_phase) begin
        phase_len = LONG_PHASE;
        restart_pct = 0;
        apply_settings(1'b1, pick_pos(), pick_pos(), 8'd255, 8'd255, 0);
      end else begin
        phase_len = $urandom_range(60, 10);
        restart_pct = $urandom_range(15);
        apply_settings($urandom_range(9) != 0, pick_pos(), pick_pos(),
                       pick_border(), pick_border(), $urandom_range(3) == 0);
      end
      for (int i = 0; i < phase_len && rand_sent < RANDOM_TICKS; i++) begin
        set_idle_mode(rand_sent);
        if (rand_sent == 100 || $urandom_range(39) == 0) pause_until_drained();
        r = ($urandom_range(99) < restart_pct);
        if (sb.enabled || r) rand_sent++;
        send_tick(r);
      end
      first_phase = 0;
    end

    // Drain and let the last frame finish its walk
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
